[sv/imu_cf_pkg.sv]
// ----------------------------------------------------------------------------
// IMU complementary filter package
// Shared constants, sequencer states and helper functions for the attitude
// estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_cf_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned CORDIC_MAX       = 24;
  localparam int unsigned ITW              = 5;   // iteration counter, covers CORDIC_MAX

  localparam int unsigned AW = 32;  // angle width, Q16.16
  localparam int unsigned CW = 34;  // CORDIC datapath width
  localparam int unsigned MAW = 17; // shared multiplier operand A
  localparam int unsigned MBW = 34; // shared multiplier operand B
  localparam int unsigned MPW = MAW + MBW;

  localparam logic [15:0]   WEIGHT_RESET = 16'd64225;
  localparam logic [AW-1:0] PI_Q16       = 32'd205887;
  localparam logic [CW-1:0] PI_HALF_Q30  = 34'd1686629713;
  localparam logic [29:0]   KINV_Q30     = 30'd652032874;
  localparam logic [12:0]   DT_ROUND     = 13'd7812;
  // ceil(2^62 / 15625): multiplying by it and dropping 62 bits gives the exact
  // quotient by 15625 for any numerator below 2^48.
  localparam logic [48:0]   RECIP_Q62    = 49'd295147905179353;
  // Six partial products; the last of them is added in at this final count.
  localparam logic [2:0]    RECIP_LAST   = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_G_MUL,
    ST_G_DSET,
    ST_G_DIV,
    ST_G_APPLY,
    ST_A_SET1,
    ST_A_IT1,
    ST_A_MLO,
    ST_A_MHI,
    ST_A_MSUM,
    ST_A_SET2,
    ST_A_IT2,
    ST_A_FIN,
    ST_A_BX1,
    ST_A_BX2,
    ST_A_BZ1,
    ST_A_BZ2,
    ST_DONE
  } state_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [CW-1:0] atan_q30(input logic [ITW-1:0] i);
    logic [CW-1:0] v;
    case (i)
      5'd0:  v = 34'd843314857;
      5'd1:  v = 34'd497837829;
      5'd2:  v = 34'd263043837;
      5'd3:  v = 34'd133525159;
      5'd4:  v = 34'd67021687;
      5'd5:  v = 34'd33543516;
      5'd6:  v = 34'd16775851;
      5'd7:  v = 34'd8388437;
      5'd8:  v = 34'd4194283;
      5'd9:  v = 34'd2097149;
      5'd10: v = 34'd1048576;
      5'd11: v = 34'd524288;
      5'd12: v = 34'd262144;
      5'd13: v = 34'd131072;
      5'd14: v = 34'd65536;
      5'd15: v = 34'd32768;
      5'd16: v = 34'd16384;
      5'd17: v = 34'd8192;
      5'd18: v = 34'd4096;
      5'd19: v = 34'd2048;
      5'd20: v = 34'd1024;
      5'd21: v = 34'd512;
      5'd22: v = 34'd256;
      5'd23: v = 34'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [AW-1:0] sat32(input logic signed [39:0] v);
    logic signed [AW-1:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[AW-1:0];
    end
    return r;
  endfunction

  // Round a Q2.30 angle to Q16.16.
  function automatic logic signed [AW-1:0] q30_to_q16(input logic signed [CW-1:0] a);
    logic signed [CW-1:0] t;
    t = (a + 34'sd8192) >>> 14;
    return t[AW-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/imu_complementary_filter_top.sv]
// ----------------------------------------------------------------------------
// IMU complementary filter
// Attitude estimator for interleaved gyro and accelerometer samples, built
// around one shared multiplier and one CORDIC shift-add unit.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel (in_valid, in_stall) carries one gyro
// or accelerometer sample. Each request produces exactly one result on the
// output channel (out_valid, out_stall) holding the angles after the update.
// The block takes one request at a time and holds in_stall high while it works.
// For a gyro sample, each of the three axes takes a multiply, a setup step, a
// division by 15625 through six partial products of a reciprocal, and an
// update step, after the accept step and before the result. A gyro sample
// before the first accelerometer sample goes straight to the result. An
// accelerometer sample runs two CORDIC vectoring passes through the shared
// shift-add unit, then blends its angles into the stored x and z angles; the
// first accelerometer sample skips the blend.
// The result sits in an output register; a new request is taken while it
// waits, but the next result is held back until the receiver stops stalling.
// Reset (rst, synchronous) clears the angles, the stored time stamp and the
// initialised flag, and loads gyro_weight with 0.98 in Q0.16. The user writes
// gyro_weight via cfg_we/cfg_wdata only while idle; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_filter_top #(
  parameter int unsigned CORDIC_STEPS = imu_cf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                mode,
  input  wire logic signed [15:0]  axis_x,
  input  wire logic signed [15:0]  axis_y,
  input  wire logic signed [15:0]  axis_z,
  input  wire logic [31:0]         stamp_us,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       angle_x,
  output logic signed [31:0]       angle_y,
  output logic signed [31:0]       angle_z,
  output logic                     initialized
);
  import imu_cf_pkg::*;

  localparam logic [ITW-1:0] LAST_IT = ITW'(CORDIC_STEPS - 1);

  state_t state, state_next;

  logic [15:0]            weight;
  logic                   first;
  logic [31:0]            prev_stamp;
  logic signed [AW-1:0]   ang_x, ang_y, ang_z;

  logic signed [15:0]     req_x, req_y, req_z;

  logic [31:0]            dt;
  logic [1:0]             axis;
  logic [2:0]             div_cnt;
  logic [63:0]            acc;
  logic [95:0]            racc;
  logic signed [MPW-1:0]  prod_q;

  logic signed [CW-1:0]   cx, cy, ca;
  logic [ITW-1:0]         it;
  logic signed [AW-1:0]   az_ang, ax_ang;

  logic                   in_take;
  logic                   out_load;

  // Shared multiplier operands
  logic signed [MAW-1:0]  mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [15:0]     rate;
  logic [15:0]            rate_mag;
  logic [15:0]            m_lo, m_hi;

  // CORDIC setup operands
  logic signed [CW-1:0]   sx, sy;
  logic signed [CW-1:0]   dxs, dys;

  // Reciprocal division
  logic [15:0]            n_chunk;
  logic [32:0]            m_chunk;
  logic [95:0]            pp_term;
  logic [33:0]            quot;

  // Gyro update
  logic signed [35:0]     delta;
  logic signed [39:0]     gyro_sum;
  logic signed [AW-1:0]   gyro_old;

  // Blend
  logic signed [51:0]     blend_s;
  logic signed [AW-1:0]   blend_acc;
  logic signed [AW-1:0]   blend_res;

  function automatic logic vec_zero_now();
    return (sx == '0) && (sy == '0);
  endfunction

  assign in_take  = in_valid && !in_stall;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    case (axis)
      2'd0:    rate = req_z;
      2'd1:    rate = req_y;
      default: rate = req_x;
    endcase
    case (axis)
      2'd0:    gyro_old = ang_x;
      2'd1:    gyro_old = ang_y;
      default: gyro_old = ang_z;
    endcase
    rate_mag = rate[15] ? (~rate + 16'd1) : rate;
  end

  assign m_lo = cx[CW-1] ? 16'd0 : cx[15:0];
  assign m_hi = cx[CW-1] ? 16'd0 : cx[31:16];

  // Partial products of the 48-bit numerator and the 49-bit reciprocal: the
  // numerator goes 16 bits at a time, the reciprocal in a low and a high part.
  always_comb begin
    case (div_cnt)
      3'd0, 3'd1: n_chunk = acc[15:0];
      3'd2, 3'd3: n_chunk = acc[31:16];
      default:    n_chunk = acc[47:32];
    endcase
    m_chunk = div_cnt[0] ? {17'd0, RECIP_Q62[48:33]} : RECIP_Q62[32:0];
  end

  // Each product is added in the cycle after it was issued.
  always_comb begin
    case (div_cnt)
      3'd1:    pp_term = 96'(prod_q[48:0]);
      3'd2:    pp_term = 96'(prod_q[48:0]) << 33;
      3'd3:    pp_term = 96'(prod_q[48:0]) << 16;
      3'd4:    pp_term = 96'(prod_q[48:0]) << 49;
      3'd5:    pp_term = 96'(prod_q[48:0]) << 32;
      3'd6:    pp_term = 96'(prod_q[48:0]) << 65;
      default: pp_term = '0;
    endcase
  end

  assign quot = racc[95:62];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_G_MUL: begin
        mul_a = {1'b0, rate_mag};
        mul_b = {2'b00, dt};
      end
      ST_G_DIV: begin
        mul_a = {1'b0, n_chunk};
        mul_b = {1'b0, m_chunk};
      end
      ST_A_MLO: begin
        mul_a = {1'b0, m_lo};
        mul_b = {4'b0000, KINV_Q30};
      end
      ST_A_MHI: begin
        mul_a = {1'b0, m_hi};
        mul_b = {4'b0000, KINV_Q30};
      end
      ST_A_BX1: begin
        mul_a = {1'b0, weight};
        mul_b = {{2{ang_x[AW-1]}}, ang_x} - {{2{ax_ang[AW-1]}}, ax_ang};
      end
      ST_A_BZ1: begin
        mul_a = {1'b0, weight};
        mul_b = {{2{ang_z[AW-1]}}, ang_z} - {{2{az_ang[AW-1]}}, az_ang};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    if (state == ST_A_SET2) begin
      sx = acc[63:30];
      sy = {{4{req_x[15]}}, req_x, 14'd0};
    end else begin
      sx = {{4{req_z[15]}}, req_z, 14'd0};
      sy = {{4{req_y[15]}}, req_y, 14'd0};
    end
  end

  assign dxs = cy >>> it;
  assign dys = cx >>> it;

  assign delta    = rate[15] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign gyro_sum = (axis == 2'd2) ? ({{8{gyro_old[AW-1]}}, gyro_old} + 40'(delta))
                                   : ({{8{gyro_old[AW-1]}}, gyro_old} - 40'(delta));

  assign blend_acc = (state == ST_A_BX2) ? ax_ang : az_ang;
  assign blend_s   = ({{4{blend_acc[AW-1]}}, blend_acc, 16'd0}) + 52'(prod_q) + 52'sd32768;
  assign blend_res = sat32(40'(blend_s >>> 16));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode) begin
            state_next = ST_A_SET1;
          end else if (first) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_G_MUL;
          end
        end
      end
      ST_G_MUL:   state_next = ST_G_DSET;
      ST_G_DSET:  state_next = ST_G_DIV;
      ST_G_DIV:   state_next = (div_cnt == RECIP_LAST) ? ST_G_APPLY : ST_G_DIV;
      ST_G_APPLY: state_next = (axis == 2'd2) ? ST_DONE : ST_G_MUL;
      ST_A_SET1:  state_next = vec_zero_now() ? ST_A_MLO : ST_A_IT1;
      ST_A_IT1:   state_next = (it == LAST_IT) ? ST_A_MLO : ST_A_IT1;
      ST_A_MLO:   state_next = ST_A_MHI;
      ST_A_MHI:   state_next = ST_A_MSUM;
      ST_A_MSUM:  state_next = ST_A_SET2;
      ST_A_SET2:  state_next = vec_zero_now() ? ST_A_FIN : ST_A_IT2;
      ST_A_IT2:   state_next = (it == LAST_IT) ? ST_A_FIN : ST_A_IT2;
      ST_A_FIN:   state_next = first ? ST_DONE : ST_A_BX1;
      ST_A_BX1:   state_next = ST_A_BX2;
      ST_A_BX2:   state_next = ST_A_BZ1;
      ST_A_BZ1:   state_next = ST_A_BZ2;
      ST_A_BZ2:   state_next = ST_DONE;
      ST_DONE:    state_next = out_load ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      weight      <= WEIGHT_RESET;
      first       <= 1'b1;
      prev_stamp  <= '0;
      ang_x       <= '0;
      ang_y       <= '0;
      ang_z       <= '0;
      out_valid   <= 1'b0;
      initialized <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        weight <= cfg_wdata;
      end
      if (out_load) begin
        out_valid   <= 1'b1;
        angle_x     <= ang_x;
        angle_y     <= ang_y;
        angle_z     <= ang_z;
        initialized <= !first;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      prod_q <= mul_a * mul_b;

      case (state)
        ST_IDLE: begin
          if (in_take) begin
            req_x     <= axis_x;
            req_y     <= axis_y;
            req_z     <= axis_z;
            axis      <= 2'd0;
            if (!mode) begin
              prev_stamp <= stamp_us;
              dt         <= stamp_us - prev_stamp;
            end
          end
        end
        ST_G_DSET: begin
          acc     <= 64'(prod_q[47:0]) + 64'(DT_ROUND);
          racc    <= '0;
          div_cnt <= '0;
        end
        ST_G_DIV: begin
          racc    <= racc + pp_term;
          div_cnt <= div_cnt + 3'd1;
        end
        ST_G_APPLY: begin
          case (axis)
            2'd0:    ang_x <= sat32(gyro_sum);
            2'd1:    ang_y <= sat32(gyro_sum);
            default: ang_z <= sat32(gyro_sum);
          endcase
          axis <= axis + 2'd1;
        end
        ST_A_SET1, ST_A_SET2: begin
          it <= '0;
          if (vec_zero_now()) begin
            cx <= '0;
            cy <= '0;
            ca <= '0;
          end else if (sx < 0) begin
            if (sy >= 0) begin
              cx <= sy;
              cy <= -sx;
              ca <= PI_HALF_Q30;
            end else begin
              cx <= -sy;
              cy <= sx;
              ca <= -PI_HALF_Q30;
            end
          end else begin
            cx <= sx;
            cy <= sy;
            ca <= '0;
          end
        end
        ST_A_IT1, ST_A_IT2: begin
          if (cy > 0) begin
            cx <= cx + dxs;
            cy <= cy - dys;
            ca <= ca + atan_q30(it);
          end else begin
            cx <= cx - dxs;
            cy <= cy + dys;
            ca <= ca - atan_q30(it);
          end
          it <= it + 1'b1;
        end
        ST_A_MLO: begin
          az_ang <= q30_to_q16(ca);
        end
        ST_A_MHI: begin
          acc <= 64'(prod_q[47:0]) + 64'd536870912;
        end
        ST_A_MSUM: begin
          acc <= acc + {prod_q[47:0], 16'd0};
        end
        ST_A_FIN: begin
          ax_ang <= q30_to_q16(ca);
          if (first) begin
            first <= 1'b0;
            ang_x <= q30_to_q16(ca);
            ang_y <= PI_Q16;
            ang_z <= az_ang;
          end
        end
        ST_A_BX2: ang_x <= blend_res;
        ST_A_BZ2: ang_z <= blend_res;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/imu_cf_checker.sv]
// ----------------------------------------------------------------------------
// IMU complementary filter port checker
// Watches the ports of the top level and flags behaviour that breaks the
// request/result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_cf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] angle_x,
  input wire logic        initialized
);

  // Nothing is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  // A held result stays offered and keeps its angle_x value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle_x))
    else $error("stalled result changed");

  // Once a request is taken the block is busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken without a busy cycle");

  // The pose, once set, stays set until reset.
  a_init_sticky: assert property (@(posedge clk) disable iff (rst)
    initialized |=> initialized)
    else $error("initialised flag dropped");

endmodule

bind imu_complementary_filter_top imu_cf_checker u_imu_cf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .angle_x     (angle_x),
  .initialized (initialized)
);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU complementary filter testbench
// Drives gyro and accelerometer samples through the valid/stall channel with
// bursts and gaps, stalls the result channel on its own pattern, and compares
// every result field by field against a bit-accurate attitude predictor or a
// directed row's fixed attitude, over several settings of the gyro weight.
// ----------------------------------------------------------------------------

module testbench;

  import imu_cf_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 235;
  localparam longint      CYCLE_LIMIT      = 3000000;
  localparam longint      HALF_PI_Q30      = 64'sd1686629713;
  localparam longint      INV_GAIN_Q30     = 64'sd652032874;
  localparam logic        MODE_GYRO        = 1'b0;
  localparam logic        MODE_ACCEL       = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [31:0]        stamp;
  } imu_sample_t;

  typedef struct packed {
    logic signed [31:0] ang_x;
    logic signed [31:0] ang_y;
    logic signed [31:0] ang_z;
    logic               init;
  } attitude_t;

  typedef struct packed {
    imu_sample_t smp;
    logic        typed;
    attitude_t   want;
  } directed_row_t;

  localparam longint ARCTAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  localparam directed_row_t DIRECTED_ROWS [15] = '{
    '{'{MODE_GYRO, 16'sd100, 16'sd200, 16'sd300, 32'd1000}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
    '{'{MODE_GYRO, -16'sd32768, -16'sd32768, -16'sd32768, 32'hFFFFFFFF}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
    '{'{MODE_ACCEL, 16'sd0, 16'sd0, 16'sd0, 32'd0}, 1'b1,
      '{32'sd0, PI_Q16, 32'sd0, 1'b1}},
    '{'{MODE_GYRO, 16'sd32767, -16'sd32768, 16'sd0, 32'd4}, 1'b0, '0},
    '{'{MODE_GYRO, 16'sd1024, 16'sd1024, 16'sd1024, 32'd1000004}, 1'b0, '0},
    '{'{MODE_GYRO, 16'sd32767, 16'sd32767, -16'sd32768, 32'h80000000}, 1'b1,
      '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1}},
    '{'{MODE_GYRO, 16'sd0, 16'sd0, 16'sd0, 32'h80000000}, 1'b1,
      '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1}},
    '{'{MODE_ACCEL, 16'sd32767, 16'sd32767, 16'sd32767, 32'd0}, 1'b0, '0},
    '{'{MODE_ACCEL, -16'sd32768, -16'sd32768, -16'sd32768, 32'hFFFFFFFF}, 1'b0, '0},
    '{'{MODE_ACCEL, 16'sd0, 16'sd100, -16'sd200, 32'd0}, 1'b0, '0},
    '{'{MODE_ACCEL, 16'sd0, -16'sd100, -16'sd200, 32'd0}, 1'b0, '0},
    '{'{MODE_ACCEL, 16'sd500, 16'sd0, 16'sd0, 32'd0}, 1'b0, '0},
    '{'{MODE_ACCEL, 16'sd0, 16'sd0, 16'sd16384, 32'd0}, 1'b0, '0},
    '{'{MODE_ACCEL, -16'sd32768, 16'sd0, 16'sd0, 32'd0}, 1'b0, '0},
    '{'{MODE_GYRO, -16'sd1, 16'sd1, -16'sd1, 32'h80000001}, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic signed [15:0] axis_x = '0;
  logic signed [15:0] axis_y = '0;
  logic signed [15:0] axis_z = '0;
  logic [31:0]        stamp_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] angle_x;
  logic signed [31:0] angle_y;
  logic signed [31:0] angle_z;
  logic               initialized;

  // Predictor state, mirrors the block's registers.
  logic signed [31:0] est_angle [3];
  logic               est_waiting;
  logic [31:0]        est_prev_stamp;
  logic [15:0]        est_weight;

  attitude_t   pending_attitudes [$];
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned gyro_sent = 0;
  int unsigned accel_sent = 0;
  int unsigned weights_used = 1;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  longint      cycles = 0;
  logic [31:0] next_stamp = 32'd2000000;

  imu_complementary_filter_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .stamp_us(stamp_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
    .initialized(initialized)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_angle(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Vectoring CORDIC: angle of (cx, cy) in Q2.30, scaled magnitude in mag.
  function automatic longint vector_angle(input longint cx, input longint cy,
                                          output longint mag);
    longint a;
    longint t;
    longint dx;
    longint dy;
    a = 0;
    if (cx == 0 && cy == 0) begin
      mag = 0;
      return 0;
    end
    if (cx < 0) begin
      if (cy >= 0) begin
        t = cx; cx = cy; cy = -t; a = HALF_PI_Q30;
      end else begin
        t = cx; cx = -cy; cy = t; a = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; a += ARCTAN_Q30[i];
      end else begin
        cx -= dx; cy += dy; a -= ARCTAN_Q30[i];
      end
    end
    mag = cx;
    return a;
  endfunction

  function automatic logic signed [31:0] round_to_q16(input longint a);
    return clamp_angle((a + 8192) >>> 14);
  endfunction

  // Rate in Q6.10 times elapsed microseconds, as a Q16.16 step.
  function automatic longint rate_step(input longint rate, input logic [31:0] dt);
    longint p;
    longint q;
    p = rate * longint'({32'd0, dt});
    q = ((p < 0 ? -p : p) + 7812) / 15625;
    return p < 0 ? -q : q;
  endfunction

  function automatic logic signed [31:0] mix_angle(input logic signed [31:0] old,
                                                   input logic signed [31:0] acc);
    longint w;
    longint sm;
    w  = longint'({48'd0, est_weight});
    sm = longint'(old) * w + longint'(acc) * (65536 - w);
    return clamp_angle((sm + 32768) >>> 16);
  endfunction

  function automatic attitude_t apply_sample(input imu_sample_t s);
    attitude_t   res;
    logic [31:0] dt;
    longint      m;
    longint      r;
    longint      unused_mag;
    logic signed [31:0] tilt_z;
    logic signed [31:0] tilt_x;
    if (s.mode == MODE_GYRO) begin
      if (est_waiting) begin
        est_prev_stamp = s.stamp;
      end else begin
        dt = s.stamp - est_prev_stamp;
        est_prev_stamp = s.stamp;
        est_angle[0] = clamp_angle(longint'(est_angle[0]) - rate_step(s.axis_z, dt));
        est_angle[1] = clamp_angle(longint'(est_angle[1]) - rate_step(s.axis_y, dt));
        est_angle[2] = clamp_angle(longint'(est_angle[2]) + rate_step(s.axis_x, dt));
      end
    end else begin
      tilt_z = round_to_q16(vector_angle(longint'(s.axis_z) * 16384,
                                         longint'(s.axis_y) * 16384, m));
      if (m < 0) m = 0;
      r = (m * INV_GAIN_Q30 + (64'sd1 << 29)) >>> 30;
      tilt_x = round_to_q16(vector_angle(r, longint'(s.axis_x) * 16384, unused_mag));
      if (est_waiting) begin
        est_waiting  = 1'b0;
        est_angle[0] = tilt_x;
        est_angle[1] = PI_Q16;
        est_angle[2] = tilt_z;
      end else begin
        est_angle[0] = mix_angle(est_angle[0], tilt_x);
        est_angle[2] = mix_angle(est_angle[2], tilt_z);
      end
    end
    res.ang_x = est_angle[0];
    res.ang_y = est_angle[1];
    res.ang_z = est_angle[2];
    res.init  = ~est_waiting;
    return res;
  endfunction

  function automatic logic signed [15:0] pick_axis();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) return 16'($signed($urandom_range(0, 4000)) - 2000);
    if (k < 90) return 16'($urandom);
    case ($urandom_range(0, 2))
      0:       return 16'sd0;
      1:       return 16'sh7FFF;
      default: return 16'sh8000;
    endcase
  endfunction

  function automatic imu_sample_t pick_sample();
    imu_sample_t s;
    int unsigned k;
    s.axis_x = pick_axis();
    s.axis_y = pick_axis();
    s.axis_z = pick_axis();
    s.mode   = ($urandom_range(0, 99) < 60) ? MODE_GYRO : MODE_ACCEL;
    k = $urandom_range(0, 99);
    if (s.mode == MODE_GYRO && k < 6) begin
      next_stamp = $urandom;
    end else if (s.mode == MODE_GYRO) begin
      next_stamp = next_stamp + $urandom_range(1, 20000);
    end
    // Accelerometer samples carry an unused stamp, which may be anything.
    s.stamp = (s.mode == MODE_GYRO) ? next_stamp : 32'($urandom);
    return s;
  endfunction

  // One request; the sender works in bursts with random gaps between them.
  task automatic send_sample(input imu_sample_t s, input logic typed,
                             input attitude_t want);
    int unsigned gap;
    attitude_t   predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    mode     <= s.mode;
    axis_x   <= s.axis_x;
    axis_y   <= s.axis_y;
    axis_z   <= s.axis_z;
    stamp_us <= s.stamp;
    do @(posedge clk); while (in_stall);
    predicted = apply_sample(s);
    pending_attitudes.push_back(typed ? want : predicted);
    burst_left--;
    if (s.mode == MODE_GYRO) gyro_sent++; else accel_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_attitudes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_weight(input logic [15:0] w);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    est_weight = w;
    weights_used++;
  endtask

  // The receiver changes its stall density now and then.
  always @(posedge clk) begin
    if (cycles % 700 == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    attitude_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** imu_complementary_filter_top: FAILED **");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_attitudes.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = pending_attitudes.pop_front();
        results_checked++;
        if (angle_x !== want.ang_x) begin
          $error("angle_x: expected %0d, got %0d", want.ang_x, angle_x);
          mismatches++;
        end
        if (angle_y !== want.ang_y) begin
          $error("angle_y: expected %0d, got %0d", want.ang_y, angle_y);
          mismatches++;
        end
        if (angle_z !== want.ang_z) begin
          $error("angle_z: expected %0d, got %0d", want.ang_z, angle_z);
          mismatches++;
        end
        if (initialized !== want.init) begin
          $error("initialized: expected %0b, got %0b", want.init, initialized);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [15:0] weights [6];
    est_angle[0]   = '0;
    est_angle[1]   = '0;
    est_angle[2]   = '0;
    est_waiting    = 1'b1;
    est_prev_stamp = '0;
    est_weight     = WEIGHT_RESET;
    weights = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'($urandom), WEIGHT_RESET};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      send_sample(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    for (int n = 0; n < RANDOM_PER_PHASE; n++) send_sample(pick_sample(), 1'b0, '0);

    foreach (weights[p]) begin
      load_weight(weights[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_sample(pick_sample(), 1'b0, '0);
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (pending_attitudes.size() != 0) begin
      $error("%0d expected results never arrived", pending_attitudes.size());
      mismatches++;
    end
    $display("Sent %0d gyro and %0d accelerometer samples under %0d gyro weights.",
             gyro_sent, accel_sent, weights_used);
    $display("Checked %0d results, %0d field mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("** imu_complementary_filter_top: PASSED **");
    end else begin
      $display("** imu_complementary_filter_top: FAILED **");
    end
    $finish;
  end

endmodule
